// ===== rtl/tlpt_pkg.sv =====
// shared types and constants for the two-level page table engine
`default_nettype none

package tlpt_pkg;

   localparam int DIR_ENTRIES = 1024;
   localparam int IDX_W       = 10;
   localparam int DIR_LSB     = 22;
   localparam int TBL_LSB     = 12;
   localparam int OFFSET_W    = 12;
   localparam int FRAME_W     = 20;

   localparam logic [1:0] OP_MAP   = 2'd0;
   localparam logic [1:0] OP_UNMAP = 2'd1;
   localparam logic [1:0] OP_XLATE = 2'd2;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_NOT_MAPPED = 2'd1;
   localparam logic [1:0] STATUS_NO_SLOTS   = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIR,
      ST_TBL
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/tlpt_if.sv =====
// request and response channel interfaces of the page table engine
`default_nettype none

interface tlpt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [31:0] virtual_address;
   logic [31:0] physical_address;
   logic [11:0] entry_flags;

   modport source (output valid, opcode, virtual_address, physical_address, entry_flags,
                   input ready);
   modport sink   (input valid, opcode, virtual_address, physical_address, entry_flags,
                   output ready);
endinterface

interface tlpt_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] translated_address;
   logic [1:0]  status;

   modport source (output valid, translated_address, status, input ready);
   modport sink   (input valid, translated_address, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/two_level_page_table_engine_unit.sv =====
// top level of the two-level page table engine
// After reset the engine sweeps both memories clear, one entry per cycle; no
// request is taken during that sweep. Each request then reads the 1024-entry
// directory memory and, from that, the page table memory (both synchronous,
// registered read). Map and unmap read the directory, then do the table
// write-back and any slot allocation; translate reads the directory, the table,
// then loads the result when the directory entry is present, and loads the
// result after the directory read alone when it is absent. The result sits in an
// output register, so the next request is taken while a result waits; the engine
// holds an item in its last step only while the output register is still full.
// Table slots are handed out in order and never freed; a map that needs a new
// table when all slots are in use writes nothing and reports out of slots.
`default_nettype none

module two_level_page_table_engine_unit #(
   parameter int TABLE_SLOTS = 16
) (
   input  wire          clock,
   input  wire          reset,
   tlpt_req_if.sink     req_chan,
   tlpt_rsp_if.source   rsp_chan
);

   localparam int TBL_DEPTH = TABLE_SLOTS * tlpt_pkg::DIR_ENTRIES;
   localparam int TBL_AW    = $clog2(TBL_DEPTH);
   localparam int SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int NF_W      = $clog2(TABLE_SLOTS + 1);

   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] slot;
   } dir_entry_type;

   // state and request registers
   tlpt_pkg::state_type state_ff, state_in;
   logic [TBL_AW-1:0]   clr_cnt_ff;
   logic [NF_W-1:0]     next_free_ff;
   logic [1:0]          op_ff;
   logic [31:0]         va_ff;
   logic [tlpt_pkg::FRAME_W-1:0] pa_ff;
   logic [11:0]         fl_ff;

   // memories
   dir_entry_type dir_mem [tlpt_pkg::DIR_ENTRIES];
   logic [31:0]   tbl_mem [TBL_DEPTH];
   dir_entry_type dir_rd_ff;
   logic [31:0]   tbl_rd_ff;

   logic                        dir_we, dir_re;
   logic [tlpt_pkg::IDX_W-1:0]  dir_wr_addr, dir_rd_addr;
   dir_entry_type               dir_wr_data;
   logic                        tbl_we, tbl_re;
   logic [TBL_AW-1:0]           tbl_wr_addr;
   logic [31:0]                 tbl_wr_data;

   // response register
   logic        rsp_valid_ff;
   logic [31:0] rsp_addr_ff;
   logic [1:0]  rsp_status_ff;
   logic        rsp_load;
   logic [31:0] rsp_addr_in;
   logic [1:0]  rsp_status_in;

   logic              accept, out_free, dir_hit, can_alloc, alloc, clr_done;
   logic [SLOT_W-1:0] slot_sel;
   logic [TBL_AW-1:0] entry_addr;

   assign accept    = req_chan.valid && req_chan.ready;
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign dir_hit   = dir_rd_ff.valid;
   assign can_alloc = next_free_ff < NF_W'(TABLE_SLOTS);
   assign slot_sel  = dir_hit ? dir_rd_ff.slot : next_free_ff[SLOT_W-1:0];
   assign entry_addr = TBL_AW'({slot_sel, va_ff[tlpt_pkg::TBL_LSB +: tlpt_pkg::IDX_W]});
   assign clr_done  = clr_cnt_ff == TBL_AW'(TBL_DEPTH - 1);
   assign dir_rd_addr = req_chan.virtual_address[tlpt_pkg::DIR_LSB +: tlpt_pkg::IDX_W];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tlpt_pkg::ST_CLEAR: begin
            if (clr_done) state_in = tlpt_pkg::ST_IDLE;
         end
         tlpt_pkg::ST_IDLE: begin
            if (accept) state_in = tlpt_pkg::ST_DIR;
         end
         tlpt_pkg::ST_DIR: begin
            if (op_ff == tlpt_pkg::OP_XLATE && dir_hit) state_in = tlpt_pkg::ST_TBL;
            else if (out_free) state_in = tlpt_pkg::ST_IDLE;
         end
         tlpt_pkg::ST_TBL: begin
            if (out_free) state_in = tlpt_pkg::ST_IDLE;
         end
         default: state_in = tlpt_pkg::ST_CLEAR;
      endcase
   end

   // outputs and memory controls
   always_comb begin
      req_chan.ready = 1'b0;
      dir_re         = 1'b0;
      dir_we         = 1'b0;
      dir_wr_addr    = va_ff[tlpt_pkg::DIR_LSB +: tlpt_pkg::IDX_W];
      dir_wr_data    = '{valid: 1'b1, slot: next_free_ff[SLOT_W-1:0]};
      tbl_we         = 1'b0;
      tbl_re         = 1'b0;
      tbl_wr_addr    = entry_addr;
      tbl_wr_data    = {pa_ff, fl_ff};
      alloc          = 1'b0;
      rsp_load       = 1'b0;
      rsp_addr_in    = '0;
      rsp_status_in  = tlpt_pkg::STATUS_NOT_MAPPED;
      case (state_ff)
         tlpt_pkg::ST_CLEAR: begin
            dir_we      = 1'b1;
            dir_wr_addr = clr_cnt_ff[tlpt_pkg::IDX_W-1:0];
            dir_wr_data = '0;
            tbl_we      = 1'b1;
            tbl_wr_addr = clr_cnt_ff;
            tbl_wr_data = '0;
         end
         tlpt_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            dir_re         = req_chan.valid;
         end
         tlpt_pkg::ST_DIR: begin
            case (op_ff)
               tlpt_pkg::OP_MAP: begin
                  if (out_free) begin
                     rsp_load = 1'b1;
                     if (dir_hit || can_alloc) begin
                        tbl_we        = 1'b1;
                        dir_we        = !dir_hit;
                        alloc         = !dir_hit;
                        rsp_status_in = tlpt_pkg::STATUS_OK;
                     end else begin
                        rsp_status_in = tlpt_pkg::STATUS_NO_SLOTS;
                     end
                  end
               end
               tlpt_pkg::OP_UNMAP: begin
                  if (out_free) begin
                     rsp_load = 1'b1;
                     if (dir_hit) begin
                        tbl_we        = 1'b1;
                        tbl_wr_data   = '0;
                        rsp_status_in = tlpt_pkg::STATUS_OK;
                     end
                  end
               end
               tlpt_pkg::OP_XLATE: begin
                  if (dir_hit) tbl_re = 1'b1;
                  else rsp_load = out_free;
               end
               default: rsp_load = out_free;
            endcase
         end
         tlpt_pkg::ST_TBL: begin
            rsp_load = out_free;
            if (tbl_rd_ff[0]) begin
               rsp_addr_in   = {tbl_rd_ff[31:tlpt_pkg::TBL_LSB],
                                va_ff[tlpt_pkg::OFFSET_W-1:0]};
               rsp_status_in = tlpt_pkg::STATUS_OK;
            end
         end
         default: ;
      endcase
   end

   // directory memory
   always_ff @(posedge clock) begin
      if (dir_we) dir_mem[dir_wr_addr] <= dir_wr_data;
      if (dir_re) dir_rd_ff <= dir_mem[dir_rd_addr];
   end

   // page table memory
   always_ff @(posedge clock) begin
      if (tbl_we) tbl_mem[tbl_wr_addr] <= tbl_wr_data;
      if (tbl_re) tbl_rd_ff <= tbl_mem[entry_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlpt_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         next_free_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == tlpt_pkg::ST_CLEAR) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (alloc) next_free_ff <= next_free_ff + 1'b1;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_chan.opcode;
         va_ff <= req_chan.virtual_address;
         pa_ff <= req_chan.physical_address[31:tlpt_pkg::TBL_LSB];
         fl_ff <= req_chan.entry_flags;
      end
      if (rsp_load) begin
         rsp_addr_ff   <= rsp_addr_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.translated_address = rsp_addr_ff;
   assign rsp_chan.status             = rsp_status_ff;

   // checks
   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= NF_W'(TABLE_SLOTS))
      else $error("slot counter past table count");

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == tlpt_pkg::ST_CLEAR |-> !req_chan.ready)
      else $error("request taken during clear sweep");

   a_alloc_step: assert property (@(posedge clock) disable iff (reset)
      alloc |=> next_free_ff == $past(next_free_ff) + 1'b1)
      else $error("slot allocation did not advance counter");

   a_no_slots_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_status_in == tlpt_pkg::STATUS_NO_SLOTS)
         |-> next_free_ff == NF_W'(TABLE_SLOTS))
      else $error("out of slots reported with slots left");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("response register overwritten");

endmodule

`default_nettype wire
